[src/fhs_pkg.sv]
// shared constants, types and arithmetic helpers for the 1d heat stencil
`timescale 1ns / 1ps

package fhs_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int BETA_W       = 16;
    localparam int STEP_W       = 16;
    localparam int REG_IDX_W    = 2;
    localparam int CFG_W        = 16;
    localparam int OUT_DATA_W   = ((SAMPLE_WIDTH + ADDR_W + 7) / 8) * 8;
    localparam int IN_DATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // laplacian, product, rounded product and sum widths
    localparam int LAP_W  = SAMPLE_WIDTH + 2;
    localparam int PROD_W = LAP_W + BETA_W + 1;
    localparam int SCL_W  = PROD_W - BETA_W;
    localparam int SUM_W  = SCL_W + 1;

    localparam logic [REG_IDX_W-1:0] REG_RATIO  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_STEPS  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_POINTS = REG_IDX_W'(2);

    localparam logic [BETA_W-1:0] RATIO_RESET  = BETA_W'(26561);
    localparam logic [STEP_W-1:0] STEPS_RESET  = STEP_W'(400);
    localparam logic [CNT_W-1:0]  POINTS_RESET = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0]  MIN_POINTS   = CNT_W'(3);

    localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1) << (BETA_W - 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } fhs_state_t;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
    } rd_tag_t;

    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic [SAMPLE_WIDTH-1:0] data;
    } wr_req_t;

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] r;
        hi = {{(SUM_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            r = hi[SAMPLE_WIDTH-1:0];
        end else if (v < lo) begin
            r = lo[SAMPLE_WIDTH-1:0];
        end else begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

[src/fhs_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module fhs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/fhs_update.sv]
// stencil update pipeline: neighbor window, laplacian, scale by ratio, round, saturate
`timescale 1ns / 1ps

module fhs_update (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [fhs_pkg::BETA_W-1:0]      beta,
    input  logic [fhs_pkg::SAMPLE_WIDTH-1:0] rd_data,
    input  fhs_pkg::rd_tag_t                tag,
    output fhs_pkg::wr_req_t                wr,
    output logic                            busy
);

    localparam int SW = fhs_pkg::SAMPLE_WIDTH;

    logic signed [SW-1:0]                   w0_reg, w1_reg;
    logic signed [fhs_pkg::LAP_W-1:0]       lap_reg, lap_next;
    logic signed [SW-1:0]                   s1_cur_reg, s2_cur_reg;
    logic [fhs_pkg::ADDR_W-1:0]             s1_addr_reg, s2_addr_reg;
    logic                                   s1_vld_reg, s1_vld_next, s2_vld_reg;
    logic signed [fhs_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic signed [fhs_pkg::PROD_W-1:0]      rnd_full;
    logic signed [fhs_pkg::SCL_W-1:0]       scaled;
    logic signed [fhs_pkg::SUM_W-1:0]       sum;

    // window holds pre-update values of the two points left of the arriving one
    always_comb begin
        lap_next = fhs_pkg::LAP_W'(signed'(rd_data)) + fhs_pkg::LAP_W'(w0_reg)
                 - (fhs_pkg::LAP_W'(w1_reg) <<< 1);
        s1_vld_next = tag.vld && (tag.addr >= fhs_pkg::ADDR_W'(2));
        prod_next = lap_reg * $signed({1'b0, beta});
        rnd_full = prod_reg + fhs_pkg::RND_BIAS;
        scaled = fhs_pkg::SCL_W'(rnd_full >>> fhs_pkg::BETA_W);
        sum = fhs_pkg::SUM_W'(s2_cur_reg) + fhs_pkg::SUM_W'(scaled);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
        end
        if (tag.vld) begin
            w0_reg <= w1_reg;
            w1_reg <= signed'(rd_data);
            lap_reg <= lap_next;
            s1_cur_reg <= w1_reg;
            s1_addr_reg <= tag.addr - fhs_pkg::ADDR_W'(1);
        end
        prod_reg <= prod_next;
        s2_cur_reg <= s1_cur_reg;
        s2_addr_reg <= s1_addr_reg;
    end

    always_comb begin
        wr.en = s2_vld_reg;
        wr.addr = s2_addr_reg;
        wr.data = fhs_pkg::sat_sample(sum);
        busy = s1_vld_reg || s2_vld_reg;
    end

endmodule

[src/ftcs_heat_stencil_1d.sv]
// Loads point_count samples (end points forced to zero) into a 64 x 16 field
// memory, applies step_count explicit heat-equation sweeps in place, then
// streams the final field out one point per transfer. Each sweep reads one
// point per cycle through the memory's single read port, then waits for the
// update pipeline to drain before the next sweep reads the memory again. Output
// issues a new read only when no read is in flight and the output register is
// free or being taken. The block takes no new samples until the last point of
// the field has been transferred.
`timescale 1ns / 1ps

module ftcs_heat_stencil_1d (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fhs_pkg::IN_DATA_W-1:0]      s_tdata,   // sample_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fhs_pkg::OUT_DATA_W-1:0]     m_tdata,   // sample_out, point_index, zero pad
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [fhs_pkg::REG_IDX_W-1:0]      cfg_wr_index,
    input  logic [fhs_pkg::CFG_W-1:0]          cfg_wr_data
);

    localparam int SW = fhs_pkg::SAMPLE_WIDTH;
    localparam int AW = fhs_pkg::ADDR_W;
    localparam int CW = fhs_pkg::CNT_W;

    fhs_pkg::fhs_state_t             state_reg, state_next;
    logic [fhs_pkg::BETA_W-1:0]      ratio_reg;
    logic [fhs_pkg::STEP_W-1:0]      steps_cfg_reg;
    logic [CW-1:0]                   points_reg;
    logic [CW-1:0]                   load_pos_reg, load_pos_next;
    logic [fhs_pkg::STEP_W-1:0]      steps_reg, steps_next;
    logic [CW-1:0]                   n_reg, n_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic                            rd_vld_reg, rd_emit_reg, rd_emit_next;
    logic [AW-1:0]                   rd_addr_q_reg;
    logic                            rd_en;
    logic                            m_valid_reg, m_valid_next;
    logic [SW-1:0]                   m_sample_reg, m_sample_next;
    logic [AW-1:0]                   m_index_reg, m_index_next;
    logic                            m_last_reg, m_last_next;

    logic [CW-1:0]                   n_use, n_last, idx;
    logic                            s_accept, load_last;
    logic [SW-1:0]                   load_val;
    logic [SW-1:0]                   ram_rd_data;
    fhs_pkg::wr_req_t                upd_wr, ram_wr;
    fhs_pkg::rd_tag_t                tag;
    logic                            upd_busy;

    // clamp point count, pick load slot
    always_comb begin
        if (points_reg < fhs_pkg::MIN_POINTS) begin
            n_use = fhs_pkg::MIN_POINTS;
        end else if (points_reg > CW'(fhs_pkg::MAX_POINTS)) begin
            n_use = CW'(fhs_pkg::MAX_POINTS);
        end else begin
            n_use = points_reg;
        end
        n_last = n_use - CW'(1);
        idx = (load_pos_reg >= n_last) ? n_last : load_pos_reg;
        load_last = (idx == n_last);
        load_val = (idx == '0 || load_last) ? '0 : s_tdata[SW-1:0];
        s_accept = s_tvalid && s_tready;
    end

    always_comb begin
        state_next = state_reg;
        load_pos_next = load_pos_reg;
        steps_next = steps_reg;
        n_next = n_reg;
        cnt_next = cnt_reg;
        rd_en = 1'b0;
        rd_emit_next = rd_emit_reg;
        m_valid_next = m_valid_reg;
        m_sample_next = m_sample_reg;
        m_index_next = m_index_reg;
        m_last_next = m_last_reg;
        case (state_reg)
            fhs_pkg::ST_LOAD: begin
                if (s_accept) begin
                    if (load_last) begin
                        load_pos_next = '0;
                        n_next = n_use;
                        cnt_next = '0;
                        steps_next = steps_cfg_reg;
                        if (steps_cfg_reg == '0) begin
                            state_next = fhs_pkg::ST_EMIT;
                        end else begin
                            state_next = fhs_pkg::ST_SWEEP;
                        end
                    end else begin
                        load_pos_next = idx + CW'(1);
                    end
                end
            end
            fhs_pkg::ST_SWEEP: begin
                rd_en = 1'b1;
                rd_emit_next = 1'b0;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == n_reg - CW'(1)) begin
                    state_next = fhs_pkg::ST_DRAIN;
                end
            end
            fhs_pkg::ST_DRAIN: begin
                // wait until the last write of this sweep has landed
                if (!rd_vld_reg && !upd_busy) begin
                    cnt_next = '0;
                    steps_next = steps_reg - fhs_pkg::STEP_W'(1);
                    if (steps_reg == fhs_pkg::STEP_W'(1)) begin
                        state_next = fhs_pkg::ST_EMIT;
                    end else begin
                        state_next = fhs_pkg::ST_SWEEP;
                    end
                end
            end
            fhs_pkg::ST_EMIT: begin
                if (!rd_vld_reg && (!m_valid_reg || m_tready) && cnt_reg < n_reg) begin
                    rd_en = 1'b1;
                    rd_emit_next = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                if (m_valid_reg && m_tready && m_last_reg) begin
                    state_next = fhs_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = fhs_pkg::ST_LOAD;
            end
        endcase
        // output register
        if (rd_vld_reg && rd_emit_reg) begin
            m_valid_next = 1'b1;
            m_sample_next = ram_rd_data;
            m_index_next = rd_addr_q_reg;
            m_last_next = (CW'(rd_addr_q_reg) == n_reg - CW'(1));
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fhs_pkg::ST_LOAD;
            ratio_reg <= fhs_pkg::RATIO_RESET;
            steps_cfg_reg <= fhs_pkg::STEPS_RESET;
            points_reg <= fhs_pkg::POINTS_RESET;
            load_pos_reg <= '0;
            steps_reg <= '0;
            n_reg <= fhs_pkg::POINTS_RESET;
            cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            rd_emit_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            load_pos_reg <= load_pos_next;
            steps_reg <= steps_next;
            n_reg <= n_next;
            cnt_reg <= cnt_next;
            rd_vld_reg <= rd_en;
            rd_emit_reg <= rd_emit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    fhs_pkg::REG_RATIO:  ratio_reg <= cfg_wr_data[fhs_pkg::BETA_W-1:0];
                    fhs_pkg::REG_STEPS:  steps_cfg_reg <= cfg_wr_data[fhs_pkg::STEP_W-1:0];
                    fhs_pkg::REG_POINTS: points_reg <= cfg_wr_data[CW-1:0];
                    default: ;
                endcase
            end
        end
        rd_addr_q_reg <= cnt_reg[AW-1:0];
        m_sample_reg <= m_sample_next;
        m_index_reg <= m_index_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        tag.vld = rd_vld_reg && !rd_emit_reg;
        tag.addr = rd_addr_q_reg;
        ram_wr = upd_wr;
        if (s_accept) begin
            ram_wr.en = 1'b1;
            ram_wr.addr = idx[AW-1:0];
            ram_wr.data = load_val;
        end
    end

    fhs_ram #(
        .WIDTH (SW),
        .DEPTH (fhs_pkg::MAX_POINTS)
    ) u_field_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    fhs_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beta    (ratio_reg),
        .rd_data (ram_rd_data),
        .tag     (tag),
        .wr      (upd_wr),
        .busy    (upd_busy)
    );

    assign s_tready = (state_reg == fhs_pkg::ST_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {(fhs_pkg::OUT_DATA_W - SW - AW)'(0), m_index_reg, m_sample_reg};
    assign m_tlast = m_last_reg;

endmodule

[src/fhs_checker.sv]
// port-level checks for the heat stencil, bound to the top level
`timescale 1ns / 1ps

module fhs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fhs_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // results only leave after reset has cleared the output
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("sample accepted while a result is pending");

    // last point transfer ends the field and reopens loading
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("field did not end after its last point");

endmodule

bind ftcs_heat_stencil_1d fhs_checker u_fhs_checker (.*);

[dv/ftcs_heat_checker.sv]
// scoreboard for the 1d heat stencil: tracks the loaded field, predicts each final field, checks output transfers
`timescale 1ns / 1ps

module ftcs_heat_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [fhs_pkg::IN_DATA_W-1:0]    s_tdata,   // sample_in
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [fhs_pkg::OUT_DATA_W-1:0]   m_tdata,   // sample_out, point_index, zero pad
    input  logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [fhs_pkg::REG_IDX_W-1:0]    cfg_wr_index,
    input  logic [fhs_pkg::CFG_W-1:0]        cfg_wr_data,
    output int                               mismatch_count,
    output int                               points_pending,
    output int                               samples_loaded,
    output int                               fields_done,
    output int                               points_checked
);
    import fhs_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic [ADDR_W-1:0]              index;
        logic                           last;
    } grid_point_t;

    grid_point_t final_field_q[$];

    logic [BETA_W-1:0]              ratio_reg;
    logic [STEP_W-1:0]              steps_reg;
    logic [CNT_W-1:0]               points_reg;
    logic signed [SAMPLE_WIDTH-1:0] heat_field [MAX_POINTS];
    int                             load_pos;

    function automatic int grid_size(input logic [CNT_W-1:0] pc);
        if (pc < MIN_POINTS) begin
            return int'(MIN_POINTS);
        end
        if (int'(pc) > MAX_POINTS) begin
            return MAX_POINTS;
        end
        return int'(pc);
    endfunction

    // one explicit update of one point: exact laplacian, rounded product, saturated sum
    function automatic logic signed [SAMPLE_WIDTH-1:0] relax_point(
        input logic signed [SAMPLE_WIDTH-1:0] left,
        input logic signed [SAMPLE_WIDTH-1:0] cur,
        input logic signed [SAMPLE_WIDTH-1:0] right,
        input logic [BETA_W-1:0]              beta
    );
        longint lap;
        longint prod;
        longint total;
        longint top_val;
        lap     = longint'(left) + longint'(right) - 2 * longint'(cur);
        prod    = lap * longint'(beta);
        total   = longint'(cur) + ((prod + (longint'(1) << (BETA_W - 1))) >>> BETA_W);
        top_val = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
        if (total > top_val) begin
            total = top_val;
        end else if (total < -top_val - 1) begin
            total = -top_val - 1;
        end
        return total[SAMPLE_WIDTH-1:0];
    endfunction

    // in-place sweeps, keeping the pre-update value of the left neighbor
    function automatic void run_sweeps(input int n);
        logic signed [SAMPLE_WIDTH-1:0] left_old;
        logic signed [SAMPLE_WIDTH-1:0] cur;
        for (int s = 0; s < int'(steps_reg); s++) begin
            left_old = heat_field[0];
            for (int j = 1; j < n - 1; j++) begin
                cur           = heat_field[j];
                heat_field[j] = relax_point(left_old, cur, heat_field[j+1], ratio_reg);
                left_old      = cur;
            end
            heat_field[0]   = '0;
            heat_field[n-1] = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint wanted);
        $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        grid_point_t want;
        int n;
        int idx;
        if (!aresetn) begin
            ratio_reg  = RATIO_RESET;
            steps_reg  = STEPS_RESET;
            points_reg = POINTS_RESET;
            load_pos   = 0;
            final_field_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_RATIO:  ratio_reg  = cfg_wr_data[BETA_W-1:0];
                    REG_STEPS:  steps_reg  = cfg_wr_data[STEP_W-1:0];
                    REG_POINTS: points_reg = cfg_wr_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                n   = grid_size(points_reg);
                idx = (load_pos > n - 1) ? n - 1 : load_pos;
                heat_field[idx] = (idx == 0 || idx == n - 1) ? '0 : s_tdata[SAMPLE_WIDTH-1:0];
                samples_loaded++;
                if (idx + 1 < n) begin
                    load_pos = idx + 1;
                end else begin
                    load_pos = 0;
                    run_sweeps(n);
                    for (int j = 0; j < n; j++) begin
                        want.value = heat_field[j];
                        want.index = ADDR_W'(j);
                        want.last  = (j == n - 1);
                        final_field_q.push_back(want);
                    end
                    fields_done++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (final_field_q.size() == 0) begin
                    report_mismatch("output transfer with no point pending", longint'(m_tdata), 0);
                end else begin
                    want = final_field_q.pop_front();
                    points_checked++;
                    if ($signed(m_tdata[SAMPLE_WIDTH-1:0]) != want.value) begin
                        report_mismatch($sformatf("sample_out at point %0d", want.index),
                                        longint'($signed(m_tdata[SAMPLE_WIDTH-1:0])),
                                        longint'(want.value));
                    end
                    if (m_tdata[SAMPLE_WIDTH +: ADDR_W] != want.index) begin
                        report_mismatch("point_index", longint'(m_tdata[SAMPLE_WIDTH +: ADDR_W]),
                                        longint'(want.index));
                    end
                    if (m_tlast != want.last) begin
                        report_mismatch($sformatf("last_point at point %0d", want.index),
                                        longint'(m_tlast), longint'(want.last));
                    end
                    if (m_tdata[OUT_DATA_W-1:SAMPLE_WIDTH+ADDR_W] != '0) begin
                        report_mismatch("tdata pad bits",
                                        longint'(m_tdata[OUT_DATA_W-1:SAMPLE_WIDTH+ADDR_W]), 0);
                    end
                end
            end
        end
        points_pending <= final_field_q.size();
    end

endmodule

[dv/ftcs_heat_stencil_1d_tb.sv]
// top of the 1d heat stencil testbench: clock, reset, stimulus, output backpressure and verdict
`timescale 1ns / 1ps

module ftcs_heat_stencil_1d_tb;
    import fhs_pkg::*;

    localparam int     CLK_PERIOD    = 12;
    localparam int     RESET_CYCLES  = 7;
    localparam int     RANDOM_ITEMS  = 300;
    localparam int     SETTLE_CYCLES = 16;
    localparam longint TIMEOUT_NS    = 60_000_000;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(3);

    logic                    aclk;
    logic                    aresetn      = 1'b0;
    logic                    s_tvalid     = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata      = '0;   // sample_in
    logic                    m_tvalid;
    logic                    m_tready     = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;             // sample_out, point_index, zero pad
    logic                    m_tlast;
    logic                    cfg_wr_en    = 1'b0;
    logic [REG_IDX_W-1:0]    cfg_wr_index = '0;
    logic [CFG_W-1:0]        cfg_wr_data  = '0;

    int mismatch_count;
    int points_pending;
    int samples_loaded;
    int fields_done;
    int points_checked;

    int items_sent = 0;
    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;

    ftcs_heat_stencil_1d dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    ftcs_heat_checker u_field_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .points_pending (points_pending),
        .samples_loaded (samples_loaded),
        .fields_done    (fields_done),
        .points_checked (points_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("ftcs_heat_stencil_1d_tb: FAIL");
        $finish;
    end

    // output side: random stall before each transfer
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic int grid_size(input logic [CNT_W-1:0] pc);
        if (pc < MIN_POINTS) begin
            return int'(MIN_POINTS);
        end
        if (int'(pc) > MAX_POINTS) begin
            return MAX_POINTS;
        end
        return int'(pc);
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
            1: return {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
            2: return SAMPLE_WIDTH'($urandom_range(0, 511) - 256);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(value);
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        items_sent++;
    endtask

    task automatic send_field(input int count);
        for (int i = 0; i < count; i++) begin
            send_sample(draw_sample());
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // hold the input until every pending point is out and the block is back to loading
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (points_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int                directed_items;
        int                n;
        int                fields;
        int                cut;
        logic [BETA_W-1:0] ratio;
        logic [STEP_W-1:0] steps;
        logic [CNT_W-1:0]  pc;
        logic [CFG_W-1:0]  wdata;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // one full field with the reset configuration
        send_field(MAX_POINTS);
        wait_idle();
        directed_items = items_sent;

        // zero steps: boundaries replaced, interior kept as loaded
        write_reg(REG_RATIO, '0);
        write_reg(REG_STEPS, '0);
        write_reg(REG_POINTS, CFG_W'(3));
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h1234);
        wait_idle();

        // point count below minimum, ratio near one: oscillation into saturation
        write_reg(REG_RATIO, 16'hFFFF);
        write_reg(REG_STEPS, CFG_W'(5));
        write_reg(REG_POINTS, '0);
        send_sample(16'h1111);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        wait_idle();

        // longest step count, stray upper bits in the point count write
        write_reg(REG_RATIO, 16'h8000);
        write_reg(REG_STEPS, 16'hFFFF);
        write_reg(REG_POINTS, 16'hFF83);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        wait_idle();

        // point count lowered mid-load ends the load on the next sample
        write_reg(REG_RATIO, 16'h4000);
        write_reg(REG_STEPS, CFG_W'(3));
        write_reg(REG_POINTS, CFG_W'(10));
        send_field(6);
        s_tvalid <= 1'b0;
        write_reg(REG_POINTS, CFG_W'(4));
        send_sample(16'h2000);
        wait_idle();

        // unused register index, then alternating extremes
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_RATIO, 16'h8000);
        write_reg(REG_STEPS, CFG_W'(2));
        write_reg(REG_POINTS, CFG_W'(5));
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        wait_idle();
        directed_items = items_sent - directed_items;

        while (items_sent - directed_items < RANDOM_ITEMS) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: ratio = '0;
                1: ratio = 16'h8000;
                2: ratio = BETA_W'($urandom_range(32769, 65535));
                default: ratio = BETA_W'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 7))
                0: pc = CNT_W'($urandom_range(0, 2));
                1: pc = CNT_W'($urandom_range(65, 127));
                2: pc = CNT_W'(MAX_POINTS);
                3: pc = CNT_W'($urandom_range(17, 63));
                default: pc = CNT_W'($urandom_range(3, 16));
            endcase
            n = grid_size(pc);
            if (n > 16) begin
                steps = STEP_W'($urandom_range(0, 8));
            end else begin
                case ($urandom_range(0, 7))
                    0: steps = '0;
                    1: steps = STEP_W'($urandom_range(61, 300));
                    2: steps = STEP_W'($urandom_range(13, 60));
                    default: steps = STEP_W'($urandom_range(1, 12));
                endcase
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_SPARE, CFG_W'($urandom));
            end
            write_reg(REG_RATIO, ratio);
            write_reg(REG_STEPS, steps);
            wdata = CFG_W'($urandom);
            wdata[CNT_W-1:0] = pc;
            write_reg(REG_POINTS, wdata);

            fields = (n > 32) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < fields; f++) begin
                if ($urandom_range(0, 5) == 0) begin
                    // partial load, then a new point count
                    cut = $urandom_range(1, n - 1);
                    send_field(cut);
                    s_tvalid <= 1'b0;
                    pc = CNT_W'($urandom_range(0, cut + 2));
                    n = grid_size(pc);
                    wdata = CFG_W'($urandom);
                    wdata[CNT_W-1:0] = pc;
                    write_reg(REG_POINTS, wdata);
                    send_field((cut >= n - 1) ? 1 : n - cut);
                end else begin
                    send_field(n);
                end
            end
            wait_idle();
        end

        $display("loaded %0d samples into %0d fields, checked %0d output points",
                 samples_loaded, fields_done, points_checked);
        $display("step counts from 0 to 65535, ratios from 0 to 65535, sizes from 3 to 64 points");
        if (mismatch_count == 0 && points_pending == 0) begin
            $display("ftcs_heat_stencil_1d_tb: PASS");
        end else begin
            $display("ftcs_heat_stencil_1d_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/fhs_pkg.sv
src/fhs_ram.sv
src/fhs_update.sv
src/ftcs_heat_stencil_1d.sv
src/fhs_checker.sv
dv/ftcs_heat_checker.sv
dv/ftcs_heat_stencil_1d_tb.sv
